// ----- src/dpod_pkg.sv -----
// shared types, widths and calendar constants for the date period overlap block
package dpod_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 15;

  // serial day number: 365 * 16383 plus leap days and month offset fits in 23 bits
  localparam int SER_W = 23;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 15;
  localparam int PROD_W = 2 * MUL_W;

  // floor(x / 100) = (x * RECIP100) >> RECIP_SH, exact for x < 43690
  localparam int RECIP_SH = 21;
  localparam logic [MUL_W-1:0] RECIP100 = MUL_W'(((1 << RECIP_SH) + 99) / 100);
  localparam logic [MUL_W-1:0] DAYS_YEAR = MUL_W'(365);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // per-date steps of the shared unit
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_Q100  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_Q400  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_QYEAR = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_BASE  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_SUM   = STEP_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATE,
    ST_CMP,
    ST_SUB,
    ST_FIN
  } dpod_state_t;

  // days before the first of the month, month clamped to 1..12
  function automatic logic [8:0] days_before(input logic [MON_W-1:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ----- src/dpod_mul.sv -----
// shared multiplier with registered product
module dpod_mul (
  input  logic                           clk,
  input  logic [dpod_pkg::MUL_W-1:0]     mul_a,
  input  logic [dpod_pkg::MUL_W-1:0]     mul_b,
  output logic [dpod_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= dpod_pkg::PROD_W'(mul_a) * dpod_pkg::PROD_W'(mul_b);
  end

endmodule

// ----- src/date_period_overlap_days.sv -----
// an accepted request runs five steps per date for four dates, then compare, subtract and finish, to out_valid
// one request at a time; in_stall stays high while a request is worked on
// requests are serialised by the single shared multiplier, issued four times per date for four dates
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active-low rst_n returns the sequencer to idle and clears out_valid
module date_period_overlap_days (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dpod_pkg::DAY_W-1:0]      in_first_start_day,
  input  logic [dpod_pkg::MON_W-1:0]      in_first_start_month,
  input  logic [dpod_pkg::YEAR_W-1:0]     in_first_start_year,
  input  logic [dpod_pkg::DAY_W-1:0]      in_first_end_day,
  input  logic [dpod_pkg::MON_W-1:0]      in_first_end_month,
  input  logic [dpod_pkg::YEAR_W-1:0]     in_first_end_year,
  input  logic [dpod_pkg::DAY_W-1:0]      in_second_start_day,
  input  logic [dpod_pkg::MON_W-1:0]      in_second_start_month,
  input  logic [dpod_pkg::YEAR_W-1:0]     in_second_start_year,
  input  logic [dpod_pkg::DAY_W-1:0]      in_second_end_day,
  input  logic [dpod_pkg::MON_W-1:0]      in_second_end_month,
  input  logic [dpod_pkg::YEAR_W-1:0]     in_second_end_year,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_periods_overlap,
  output logic [dpod_pkg::CNT_W-1:0]      out_overlap_days
);

  localparam int SER_W  = dpod_pkg::SER_W;
  localparam int MUL_W  = dpod_pkg::MUL_W;
  localparam int PROD_W = dpod_pkg::PROD_W;
  localparam int SH     = dpod_pkg::RECIP_SH;

  dpod_pkg::dpod_state_t state_r, state_nxt;

  // captured dates: 0 first start, 1 first end, 2 second start, 3 second end
  logic [dpod_pkg::DAY_W-1:0]  day_r [4];
  logic [dpod_pkg::MON_W-1:0]  mon_r [4];
  logic [dpod_pkg::YEAR_W-1:0] yr_r  [4];
  logic [SER_W-1:0]            ser_r [4];

  logic [1:0]                  idx_r;
  logic [dpod_pkg::STEP_W-1:0] step_r;

  // quotients from the shared multiplier
  logic [PROD_W-SH-1:0] q100a_r;   // (yr + 99) / 100
  logic [PROD_W-SH-1:0] q400_r;    // (yr + 399) / 400
  logic [PROD_W-SH-1:0] qy_r;      // yr / 100

  logic [SER_W-1:0] lo_r, hi_r;

  logic                        ovl_r;
  logic [dpod_pkg::CNT_W-1:0]  cnt_r;
  logic                        out_valid_r;
  logic                        ovl_out_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;

  logic                        accept;
  logic                        load_out;
  logic [dpod_pkg::YEAR_W-1:0] cur_yr;
  logic [MUL_W-1:0]            yr15;
  logic [MUL_W-1:0]            leaps4;
  logic [MUL_W-1:0]            q100_x100;
  logic                        is_leap;
  logic [SER_W-1:0]            ser_sum;
  logic [SER_W-1:0]            span;
  logic [SER_W-1:0]            lo_sel, hi_sel;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != dpod_pkg::ST_IDLE);
  assign load_out  = (state_r == dpod_pkg::ST_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_periods_overlap = ovl_out_r;

  // operands of the date under work
  assign cur_yr = yr_r[idx_r];
  assign yr15   = {1'b0, cur_yr};

  dpod_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // shared multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == dpod_pkg::ST_DATE) begin
      unique case (step_r)
        dpod_pkg::STEP_Q100: begin
          mul_a = yr15 + MUL_W'(99);
          mul_b = dpod_pkg::RECIP100;
        end
        dpod_pkg::STEP_Q400: begin
          mul_a = (yr15 + MUL_W'(399)) >> 2;
          mul_b = dpod_pkg::RECIP100;
        end
        dpod_pkg::STEP_QYEAR: begin
          mul_a = yr15;
          mul_b = dpod_pkg::RECIP100;
        end
        dpod_pkg::STEP_BASE: begin
          mul_a = yr15;
          mul_b = dpod_pkg::DAYS_YEAR;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // serial day: 365*yr + leap days before yr + month offset + leap fixup + day
  always_comb begin
    leaps4    = (yr15 + MUL_W'(3)) >> 2;
    q100_x100 = MUL_W'({qy_r, 6'b0}) + MUL_W'({qy_r, 5'b0}) + MUL_W'({qy_r, 2'b0});
    // divisible by 4, and either not by 100 or by 400
    is_leap   = (cur_yr[1:0] == 2'b00) &&
                ((q100_x100 != yr15) || (qy_r[1:0] == 2'b00));
    ser_sum   = prod_r[SER_W-1:0]
              + SER_W'(leaps4)
              - SER_W'(q100a_r)
              + SER_W'(q400_r)
              + SER_W'(dpod_pkg::days_before(mon_r[idx_r]))
              + SER_W'(is_leap && (mon_r[idx_r] > 4'd2))
              + SER_W'(day_r[idx_r]);
  end

  // overlap window: later start, earlier end
  assign lo_sel = (ser_r[0] > ser_r[2]) ? ser_r[0] : ser_r[2];
  assign hi_sel = (ser_r[1] < ser_r[3]) ? ser_r[1] : ser_r[3];
  assign span   = hi_r - lo_r + SER_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpod_pkg::ST_IDLE: if (accept) state_nxt = dpod_pkg::ST_DATE;
      dpod_pkg::ST_DATE: begin
        if (step_r == dpod_pkg::STEP_SUM && idx_r == 2'd3) state_nxt = dpod_pkg::ST_CMP;
      end
      dpod_pkg::ST_CMP:  state_nxt = dpod_pkg::ST_SUB;
      dpod_pkg::ST_SUB:  state_nxt = dpod_pkg::ST_FIN;
      dpod_pkg::ST_FIN:  if (load_out) state_nxt = dpod_pkg::ST_IDLE;
      default:           state_nxt = dpod_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpod_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      step_r <= dpod_pkg::STEP_Q100;
    end else if (accept) begin
      idx_r  <= '0;
      step_r <= dpod_pkg::STEP_Q100;
    end else if (state_r == dpod_pkg::ST_DATE) begin
      if (step_r == dpod_pkg::STEP_SUM) begin
        step_r <= dpod_pkg::STEP_Q100;
        idx_r  <= idx_r + 2'd1;
      end else begin
        step_r <= step_r + dpod_pkg::STEP_W'(1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      day_r[0] <= in_first_start_day;
      mon_r[0] <= in_first_start_month;
      yr_r[0]  <= in_first_start_year;
      day_r[1] <= in_first_end_day;
      mon_r[1] <= in_first_end_month;
      yr_r[1]  <= in_first_end_year;
      day_r[2] <= in_second_start_day;
      mon_r[2] <= in_second_start_month;
      yr_r[2]  <= in_second_start_year;
      day_r[3] <= in_second_end_day;
      mon_r[3] <= in_second_end_month;
      yr_r[3]  <= in_second_end_year;
    end
  end

  // quotient and serial day capture, in the step after issue
  always_ff @(posedge clk) begin
    if (state_r == dpod_pkg::ST_DATE) begin
      unique case (step_r)
        dpod_pkg::STEP_Q400:  q100a_r <= prod_r[PROD_W-1:SH];
        dpod_pkg::STEP_QYEAR: q400_r  <= prod_r[PROD_W-1:SH];
        dpod_pkg::STEP_BASE:  qy_r    <= prod_r[PROD_W-1:SH];
        dpod_pkg::STEP_SUM:   ser_r[idx_r] <= ser_sum;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == dpod_pkg::ST_CMP) begin
      lo_r <= lo_sel;
      hi_r <= hi_sel;
    end
  end

  // overlap flag and saturated count
  always_ff @(posedge clk) begin
    if (state_r == dpod_pkg::ST_SUB) begin
      ovl_r <= (lo_r <= hi_r);
      if (lo_r > hi_r) begin
        cnt_r <= '0;
      end else if (span > SER_W'(dpod_pkg::CNT_MAX)) begin
        cnt_r <= dpod_pkg::CNT_MAX;
      end else begin
        cnt_r <= span[dpod_pkg::CNT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_overlap_days <= cnt_r;
    end
  end

  // flag register follows the same load
  always_ff @(posedge clk) begin
    if (load_out) begin
      ovl_out_r <= ovl_r;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the date period overlap day counter
`timescale 1ns / 100ps

module tb_top;
  import dpod_pkg::*;

  // one calendar date as the block sees it, raw field widths
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } cal_date_t;

  // one request: two periods, each a start and an end date
  typedef struct packed {
    cal_date_t first_start;
    cal_date_t first_end;
    cal_date_t second_start;
    cal_date_t second_end;
  } dual_period_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] days;
  } overlap_result_t;

  // directed row: the request, and a hand-written answer where known is set
  typedef struct packed {
    cal_date_t        fs;
    cal_date_t        fe;
    cal_date_t        ss;
    cal_date_t        se;
    bit               known;
    logic             hit;
    logic [CNT_W-1:0] days;
  } directed_row_t;

  localparam int N_DIRECTED    = 24;
  localparam int N_RANDOM      = 800;
  localparam int MAX_PRINTS    = 40;
  localparam int DRAIN_CYCLES  = 60;

  // days before the first of each month in a common year
  localparam int unsigned MONTH_OFFSET [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  dual_period_t in_req;
  logic         out_valid;
  logic         out_stall;
  logic         out_periods_overlap;
  logic [CNT_W-1:0] out_overlap_days;

  overlap_result_t pending_overlaps [$];
  int              mismatch_count;
  int              printed_lines;

  date_period_overlap_days i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_start_day    (in_req.first_start.day),
    .in_first_start_month  (in_req.first_start.month),
    .in_first_start_year   (in_req.first_start.year),
    .in_first_end_day      (in_req.first_end.day),
    .in_first_end_month    (in_req.first_end.month),
    .in_first_end_year     (in_req.first_end.year),
    .in_second_start_day   (in_req.second_start.day),
    .in_second_start_month (in_req.second_start.month),
    .in_second_start_year  (in_req.second_start.year),
    .in_second_end_day     (in_req.second_end.day),
    .in_second_end_month   (in_req.second_end.month),
    .in_second_end_year    (in_req.second_end.year),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_periods_overlap   (out_periods_overlap),
    .out_overlap_days      (out_overlap_days)
  );

  // directed requests: extremes, ordering, leap rules and out-of-range fields
  directed_row_t directed_rows [N_DIRECTED] = '{
    // one shared day
    '{'{1, 1, 2000}, '{1, 1, 2000}, '{1, 1, 2000}, '{1, 1, 2000}, 1, 1, 1},
    // clearly disjoint
    '{'{1, 1, 2000}, '{10, 1, 2000}, '{1, 2, 2000}, '{10, 2, 2000}, 1, 0, 0},
    // adjacent but not sharing a day
    '{'{1, 1, 2000}, '{9, 1, 2000}, '{10, 1, 2000}, '{20, 1, 2000}, 1, 0, 0},
    // touching on one day
    '{'{1, 1, 2000}, '{10, 1, 2000}, '{10, 1, 2000}, '{20, 1, 2000}, 1, 1, 1},
    // later period given first
    '{'{10, 1, 2000}, '{20, 1, 2000}, '{1, 1, 2000}, '{10, 1, 2000}, 1, 1, 1},
    // one period inside the other
    '{'{1, 1, 2000}, '{31, 12, 2000}, '{10, 6, 2000}, '{20, 6, 2000}, 1, 1, 11},
    // first period ends before it starts
    '{'{10, 1, 2000}, '{1, 1, 2000}, '{1, 1, 2000}, '{10, 1, 2000}, 1, 0, 0},
    // both periods reversed
    '{'{20, 5, 2010}, '{1, 5, 2010}, '{25, 5, 2010}, '{2, 5, 2010}, 1, 0, 0},
    // whole valid calendar, saturates
    '{'{1, 1, 1}, '{31, 12, 9999}, '{1, 1, 1}, '{31, 12, 9999}, 1, 1, CNT_MAX},
    // all-zero start to all-ones end, saturates
    '{'{0, 0, 0}, '{31, 15, 16383}, '{0, 0, 0}, '{31, 15, 16383}, 1, 1, CNT_MAX},
    // top corner, single day
    '{'{31, 15, 16383}, '{31, 15, 16383}, '{31, 15, 16383}, '{31, 15, 16383}, 1, 1, 1},
    // bottom corner, single day
    '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 1, 1, 1},
    // across a leap day in a year divisible by 400
    '{'{28, 2, 2000}, '{1, 3, 2000}, '{28, 2, 2000}, '{1, 3, 2000}, 0, 0, 0},
    // century year without leap day
    '{'{28, 2, 1900}, '{1, 3, 1900}, '{1, 2, 1900}, '{31, 3, 1900}, 0, 0, 0},
    // long span over century years
    '{'{28, 2, 2100}, '{1, 3, 2400}, '{1, 1, 2100}, '{1, 3, 2100}, 0, 0, 0},
    // year zero counts as leap
    '{'{28, 2, 0}, '{1, 3, 0}, '{28, 2, 0}, '{1, 3, 0}, 0, 0, 0},
    // month zero reads as january
    '{'{5, 0, 2000}, '{5, 0, 2000}, '{5, 1, 2000}, '{5, 1, 2000}, 1, 1, 1},
    // months above twelve read as december
    '{'{5, 13, 2000}, '{5, 15, 2000}, '{5, 12, 2000}, '{5, 12, 2000}, 1, 1, 1},
    // day zero is the last day of the month before
    '{'{0, 3, 2000}, '{0, 3, 2000}, '{29, 2, 2000}, '{29, 2, 2000}, 1, 1, 1},
    // day past the month length runs into the next month
    '{'{31, 2, 2001}, '{31, 2, 2001}, '{3, 3, 2001}, '{3, 3, 2001}, 1, 1, 1},
    // day zero of january falls in the year before
    '{'{0, 1, 2001}, '{0, 1, 2001}, '{31, 12, 2000}, '{31, 12, 2000}, 1, 1, 1},
    // one day short of the count limit
    '{'{1, 1, 2001}, '{16, 9, 2090}, '{1, 1, 2001}, '{16, 9, 2090}, 0, 0, 0},
    // right at the count limit
    '{'{1, 1, 2001}, '{17, 9, 2090}, '{1, 1, 2001}, '{17, 9, 2090}, 0, 0, 0},
    // one day over the count limit
    '{'{1, 1, 2001}, '{18, 9, 2090}, '{1, 1, 2001}, '{18, 9, 2090}, 0, 0, 0}
  };

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      2:            return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // day number counted from the first of january, year zero
  function automatic int unsigned day_number(input cal_date_t dt);
    int unsigned mon;
    int unsigned yr;
    int unsigned n;
    mon = dt.month;
    yr  = dt.year;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    n = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + MONTH_OFFSET[mon-1];
    if (mon > 2 && is_leap(yr)) n++;
    return n + dt.day;
  endfunction

  // shared span runs from the later start to the earlier end
  function automatic overlap_result_t predict_overlap(input dual_period_t q);
    overlap_result_t r;
    int unsigned s1, e1, s2, e2, lo, hi, span;
    s1 = day_number(q.first_start);
    e1 = day_number(q.first_end);
    s2 = day_number(q.second_start);
    e2 = day_number(q.second_end);
    lo = (s1 > s2) ? s1 : s2;
    hi = (e1 < e2) ? e1 : e2;
    r = '0;
    if (lo <= hi) begin
      span   = hi - lo + 1;
      r.hit  = 1'b1;
      r.days = (span > CNT_MAX) ? CNT_MAX : CNT_W'(span);
    end
    return r;
  endfunction

  function automatic cal_date_t random_date(input int unsigned lo_year,
                                            input int unsigned hi_year);
    cal_date_t dt;
    dt.year  = YEAR_W'($urandom_range(hi_year, lo_year));
    dt.month = MON_W'($urandom_range(12, 1));
    dt.day   = DAY_W'($urandom_range(month_length(dt.month, dt.year), 1));
    return dt;
  endfunction

  // mostly well-formed periods in a shared window of years, some bent out of range,
  // some fully random bits
  function automatic dual_period_t random_request();
    cal_date_t   dates [4];
    cal_date_t   tmp;
    int unsigned pick, window, base, k, idx;
    pick = $urandom_range(99);
    if (pick < 15) return dual_period_t'({$urandom(), $urandom(), $urandom()});
    k = $urandom_range(9);
    window = (k < 5) ? 0 : (k < 8) ? 1 : (k < 9) ? 4 : 130;
    base = $urandom_range(9999 - window, 1);
    for (int i = 0; i < 4; i++) dates[i] = random_date(base, base + window);
    // keep most periods in order, let a few run backward
    for (int i = 0; i < 4; i += 2) begin
      if ($urandom_range(9) != 0 && day_number(dates[i]) > day_number(dates[i+1])) begin
        tmp = dates[i];
        dates[i] = dates[i+1];
        dates[i+1] = tmp;
      end
    end
    if (pick >= 85) begin
      idx = $urandom_range(3);
      k   = $urandom_range(3);
      case ($urandom_range(2))
        0:       dates[idx].day   = (k == 0) ? '0 : DAY_W'(28 + k);
        1:       dates[idx].month = (k == 0) ? '0 : MON_W'(12 + k);
        default: dates[idx].year  = (k < 2) ? '0 : YEAR_W'($urandom_range(16383, 10000));
      endcase
    end
    return '{dates[0], dates[1], dates[2], dates[3]};
  endfunction

  // mostly no gap, some short ones, a rare long one
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 65) return 0;
    if (k < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (printed_lines < MAX_PRINTS) begin
      printed_lines++;
      $display("[%0t] ERROR %s", $realtime, what);
    end
  endtask

  // present one request, hold it until taken, then queue its expected answer
  task automatic send_request(input dual_period_t q, input overlap_result_t want,
                              input bit may_idle);
    int unsigned gap;
    gap = may_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_overlaps.push_back(want);
  endtask

  // free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // main sequence: reset, directed table, random requests, drain
  initial begin
    dual_period_t    q;
    overlap_result_t want;
    int              sent;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    mismatch_count = 0;
    printed_lines  = 0;
    sent           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, hand answers where obvious, predictor elsewhere
    foreach (directed_rows[i]) begin
      q = '{directed_rows[i].fs, directed_rows[i].fe, directed_rows[i].ss, directed_rows[i].se};
      if (directed_rows[i].known) want = '{directed_rows[i].hit, directed_rows[i].days};
      else want = predict_overlap(q);
      send_request(q, want, 1'b1);
      sent++;
    end

    // random part; every fourth stretch of 64 requests runs back to back
    repeat (N_RANDOM) begin
      q = random_request();
      send_request(q, predict_overlap(q), ((sent / 64) % 4) != 3);
      sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // wait for every answer, then give stray results a chance to show up
    while (pending_overlaps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("date_period_overlap_days: match");
    else $display("date_period_overlap_days: mismatch");
    $finish;
  end

  // receiver backpressure: bursts of stall, with stretches of none at all
  initial begin
    int unsigned k;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(300, 100)) @(negedge clk) out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(20, 1)) @(negedge clk) out_stall <= 1'b0;
        k = $urandom_range(9);
        repeat ((k == 0) ? $urandom_range(50, 15) : $urandom_range(4, 1))
          @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  // result checker: each taken result against the oldest pending answer
  always @(posedge clk) begin : check_results
    overlap_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_overlaps.size() == 0) begin
        report_mismatch($sformatf("result %0b/%0d with no request pending",
                                  out_periods_overlap, out_overlap_days));
      end else begin
        want = pending_overlaps.pop_front();
        if (out_periods_overlap !== want.hit)
          report_mismatch($sformatf("overlap flag %0b, expected %0b",
                                    out_periods_overlap, want.hit));
        if (out_overlap_days !== want.days)
          report_mismatch($sformatf("overlap days %0d, expected %0d",
                                    out_overlap_days, want.days));
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("date_period_overlap_days: mismatch");
    $finish;
  end

endmodule
